>>> hw/rtl/clt_pkg.sv
// Shared types and constants for the credential lease table.
package clt_pkg;

  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned USER_W      = 32;
  localparam int unsigned PROC_W      = 31;
  localparam int unsigned STAMP_W     = 64;
  localparam int unsigned SLOT_W      = 4;
  localparam int unsigned COUNT_W     = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_GRANT  = 2'd1,
    FN_REVOKE = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef struct packed {
    logic [USER_W-1:0]  user;
    logic [PROC_W-1:0]  process;
    logic [STAMP_W-1:0] stamp;
  } key_t;

  typedef struct packed {
    logic full;   // user, process and stamp all equal
    logic loose;  // user and process equal, stamp equal or wildcard
  } match_t;

endpackage

>>> hw/rtl/clt_match.sv
// Key comparator: full match and revoke match with zero-stamp wildcard.
module clt_match
  import clt_pkg::*;
(
  input  key_t   key,
  input  key_t   entry,
  output match_t hit
);

  logic id_eq;
  logic stamp_eq;

  assign id_eq     = (key.user == entry.user) && (key.process == entry.process);
  assign stamp_eq  = (key.stamp == entry.stamp);
  assign hit.full  = id_eq && stamp_eq;
  assign hit.loose = id_eq && (stamp_eq || (key.stamp == '0));

endmodule

>>> hw/rtl/credential_lease_table_core.sv
// Top level of the credential lease table: entry memory, scan sequencer, result register.
// An accepted input word passes the scan, drain and finish states, then the result register.
// A new word is taken only in the idle state, so words do not overlap; the scan reads
//   one entry per cycle through the single read port of the entry memory.
// The result register frees the sequencer, so a new word is taken while a result waits.
// Reset: synchronous, clears all valid bits and control state; no clearing pass.
module credential_lease_table_core
  import clt_pkg::*;
#(
  parameter int unsigned ENTRIES = ENTRIES_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          func,
  input  logic [USER_W-1:0]   user_id,
  input  logic [PROC_W-1:0]   process_id,
  input  logic [STAMP_W-1:0]  start_stamp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                present,
  output logic [SLOT_W-1:0]   slot_index,
  output logic [COUNT_W-1:0]  cleared_count
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,  // issue one entry read per cycle
    S_DRAIN = 4'b0100,  // compare stage finishes the last entry
    S_FIN   = 4'b1000   // commit grant, load result word
  } state_t;

  state_t state;
  state_t state_next;

  // Request held for the whole scan
  func_t op;
  key_t  req_key;

  // Entry store: keys in memory, valid bits in flops cleared by reset
  key_t             mem [ENTRIES];
  key_t             rd_data;
  logic [ENTRIES-1:0] valid;

  // Scan pipeline: read issue then compare
  logic [IDX_W-1:0] rd_idx;
  logic             cmp_vld;
  logic [IDX_W-1:0] cmp_idx;
  match_t           hit;
  logic             cmp_live;
  logic             hit_full;
  logic             hit_rev;

  // Scan results
  logic             found;
  logic [IDX_W-1:0] found_idx;
  logic             free_seen;
  logic [IDX_W-1:0] free_idx;
  logic [COUNT_W-1:0] cnt;
  logic [IDX_W-1:0] grant_slot;

  logic in_go;
  logic fin_go;
  logic mem_we;

  assign in_ready = (state == S_IDLE);
  assign in_go    = in_valid && in_ready;
  assign fin_go   = (state == S_FIN) && (!out_valid || out_ready);
  assign mem_we   = fin_go && (op == FN_GRANT);

  // Matching entry first, else lowest free slot, else slot 0 (free_idx stays 0)
  assign grant_slot = found ? found_idx : free_idx;

  clt_match u_match (
    .key   (req_key),
    .entry (rd_data),
    .hit   (hit)
  );

  assign cmp_live = cmp_vld && valid[cmp_idx];
  assign hit_full = cmp_live && hit.full;
  assign hit_rev  = cmp_live && hit.loose && (op == FN_REVOKE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_go) state_next = S_SCAN;
      S_SCAN:  if (rd_idx == LAST_IDX) state_next = S_DRAIN;
      S_DRAIN: state_next = S_FIN;
      S_FIN:   if (fin_go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      cmp_vld <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= (state == S_SCAN);
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (in_go) begin
      op            <= func_t'(func);
      req_key.user    <= user_id;
      req_key.process <= process_id;
      req_key.stamp   <= start_stamp;
    end
  end

  // Entry memory: one read, one write per cycle, registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[grant_slot] <= req_key;
    end
    rd_data <= mem[rd_idx];
  end

  // Read issue counter and compare stage index
  always_ff @(posedge clk) begin
    if (in_go) begin
      rd_idx <= '0;
    end else if ((state == S_SCAN) && (rd_idx != LAST_IDX)) begin
      rd_idx <= rd_idx + 1'b1;
    end
    cmp_idx <= rd_idx;
  end

  // Valid bits: revoke clears during the scan, grant sets at commit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (hit_rev) begin
        valid[cmp_idx] <= 1'b0;
      end
      if (mem_we) begin
        valid[grant_slot] <= 1'b1;
      end
    end
  end

  // Scan bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      found     <= 1'b0;
      found_idx <= '0;
      free_seen <= 1'b0;
      free_idx  <= '0;
      cnt       <= '0;
    end else if (in_go) begin
      found     <= 1'b0;
      found_idx <= '0;
      free_seen <= 1'b0;
      free_idx  <= '0;
      cnt       <= '0;
    end else if (cmp_vld) begin
      if (hit_full && !found) begin
        found     <= 1'b1;
        found_idx <= cmp_idx;
      end
      if (!valid[cmp_idx] && !free_seen) begin
        free_seen <= 1'b1;
        free_idx  <= cmp_idx;
      end
      if (hit_rev && (cnt != COUNT_MAX)) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      unique case (op)
        FN_LOOKUP: begin
          present       <= found;
          slot_index    <= SLOT_W'(found_idx);
          cleared_count <= '0;
        end
        FN_GRANT: begin
          present       <= found;
          slot_index    <= SLOT_W'(grant_slot);
          cleared_count <= '0;
        end
        FN_REVOKE: begin
          present       <= (cnt != '0);
          slot_index    <= '0;
          cleared_count <= cnt;
        end
        default: begin
          present       <= 1'b0;
          slot_index    <= '0;
          cleared_count <= '0;
        end
      endcase
    end
  end

  // A committed grant leaves its slot valid
  a_grant_sets_valid: assert property (@(posedge clk) disable iff (rst)
    (fin_go && (op == FN_GRANT)) |=> valid[grant_slot])
    else $error("grant slot not valid after commit");

  // A cleared count always comes with present and slot 0
  a_revoke_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (cleared_count != '0)) |-> (present && (slot_index == '0)))
    else $error("revoke result fields inconsistent");

  // Compare stage only runs while scanning or draining
  a_cmp_window: assert property (@(posedge clk) disable iff (rst)
    cmp_vld |-> ((state == S_SCAN) || (state == S_DRAIN)))
    else $error("compare stage active outside scan");

  // Input is never taken while a scan is in flight
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> !in_ready)
    else $error("input ready during scan");

endmodule

>>> tb/lease_table_mirror_pkg.sv
`timescale 1ns / 1ps
// Mirror of the lease table: predicts each reply word and compares the block's output against it.
package lease_table_mirror_pkg;
  import clt_pkg::*;

  localparam int unsigned SLOTS = ENTRIES_DEF;

  typedef struct {
    logic               present;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] cleared;
  } lease_reply_t;

  class lease_table_mirror;
    bit                 ent_valid   [SLOTS];
    logic [USER_W-1:0]  ent_user    [SLOTS];
    logic [PROC_W-1:0]  ent_process [SLOTS];
    logic [STAMP_W-1:0] ent_stamp   [SLOTS];
    lease_reply_t       replies_due [$];
    int unsigned        fails;

    function new();
      foreach (ent_valid[i]) begin
        ent_valid[i]   = 1'b0;
        ent_user[i]    = '0;
        ent_process[i] = '0;
        ent_stamp[i]   = '0;
      end
      fails = 0;
    endfunction

    function bit key_hit(int unsigned i, logic [USER_W-1:0] u, logic [PROC_W-1:0] p,
                         logic [STAMP_W-1:0] s);
      return ent_valid[i] && ent_user[i] == u && ent_process[i] == p && ent_stamp[i] == s;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction

    function void flag(string msg);
      fails++;
      if (fails <= 10) $display("mismatch %0d: %s", fails, msg);
    endfunction

    // Apply one accepted request word to the mirrored table, queue the reply due.
    function void note_request(func_t f, logic [USER_W-1:0] u, logic [PROC_W-1:0] p,
                               logic [STAMP_W-1:0] s);
      lease_reply_t r;
      int unsigned  slot;
      int unsigned  n;
      bit           found;
      bit           have_free;
      r.present = 1'b0;
      r.slot    = '0;
      r.cleared = '0;
      slot      = 0;
      n         = 0;
      found     = 1'b0;
      have_free = 1'b0;
      case (f)
        FN_LOOKUP: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (key_hit(i, u, p, s)) begin
              r.present = 1'b1;
              r.slot    = SLOT_W'(i);
              break;
            end
          end
        end
        FN_GRANT: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (key_hit(i, u, p, s)) begin
              slot  = i;
              found = 1'b1;
              break;
            end
            if (!ent_valid[i] && !have_free) begin
              slot      = i;
              have_free = 1'b1;
            end
          end
          // full table with no match: slot stays 0
          ent_valid[slot]   = 1'b1;
          ent_user[slot]    = u;
          ent_process[slot] = p;
          ent_stamp[slot]   = s;
          r.present = found;
          r.slot    = SLOT_W'(slot);
        end
        FN_REVOKE: begin
          for (int i = 0; i < SLOTS; i++) begin
            if (ent_valid[i] && ent_user[i] == u && ent_process[i] == p &&
                (s == '0 || ent_stamp[i] == s)) begin
              ent_valid[i]   = 1'b0;
              ent_user[i]    = '0;
              ent_process[i] = '0;
              ent_stamp[i]   = '0;
              n++;
            end
          end
          r.present = (n != 0);
          r.cleared = (n > COUNT_MAX) ? COUNT_MAX : COUNT_W'(n);
        end
        default: ;
      endcase
      replies_due.push_back(r);
    endfunction

    function void check_reply(logic pr, logic [SLOT_W-1:0] sl, logic [COUNT_W-1:0] cnt);
      lease_reply_t r;
      if (replies_due.size() == 0) begin
        flag($sformatf("reply word with none due: present=%0b slot=%0d cleared=%0d",
                       pr, sl, cnt));
        return;
      end
      r = replies_due.pop_front();
      if (pr !== r.present || sl !== r.slot || cnt !== r.cleared)
        flag($sformatf("expected present=%0b slot=%0d cleared=%0d, got %0b %0d %0d",
                       r.present, r.slot, r.cleared, pr, sl, cnt));
    endfunction
  endclass

endpackage

>>> tb/tb.sv
`timescale 1ns / 1ps
// Top of the lease table bench: clock, reset, request and reply drivers, phase sequencing.
module tb;
  import clt_pkg::*;
  import lease_table_mirror_pkg::*;

  // generous cap on the run length
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned     PHASE_WORDS = 440;
  localparam int unsigned     HOLD_CYCLES = 300;

  logic               clk;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic [1:0]         func        = '0;
  logic [USER_W-1:0]  user_id     = '0;
  logic [PROC_W-1:0]  process_id  = '0;
  logic [STAMP_W-1:0] start_stamp = '0;
  logic               out_ready   = 1'b0;
  logic               in_ready;
  logic               out_valid;
  logic               present;
  logic [SLOT_W-1:0]  slot_index;
  logic [COUNT_W-1:0] cleared_count;

  // per-cycle odds (of 100) of the sender idling and the receiver stalling
  int unsigned     idle_pct   = 0;
  int unsigned     stall_pct  = 0;
  bit              hold_start = 1'b0;
  longint unsigned cycles     = 0;

  // key pools, so that lookups, reuses and revokes actually find entries
  logic [USER_W-1:0]  user_pool  [4];
  logic [PROC_W-1:0]  proc_pool  [3];
  logic [STAMP_W-1:0] stamp_pool [4];

  lease_table_mirror mirror = new();

  credential_lease_table_core i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .user_id       (user_id),
    .process_id    (process_id),
    .start_stamp   (start_stamp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .present       (present),
    .slot_index    (slot_index),
    .cleared_count (cleared_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Reply side. Sampling just after the edge sees the pre-edge values, so the
  // check matches what the block saw. A long hold-off is timed here, cycle by
  // cycle, once the stimulus asks for one.
  initial begin : reply_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
      @(posedge clk);
      if (!rst && out_valid && out_ready) mirror.check_reply(present, slot_index, cleared_count);
    end
  end

  // Offer one request word; valid stays up with a steady payload until taken.
  // A word following straight on keeps valid high, so it is never dropped and
  // re-raised within one step.
  task automatic offer_word(input logic [1:0] f, input logic [USER_W-1:0] u,
                            input logic [PROC_W-1:0] p, input logic [STAMP_W-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= f;
    user_id     <= u;
    process_id  <= p;
    start_stamp <= s;
    do @(posedge clk); while (!in_ready);
    mirror.note_request(func_t'(f), u, p, s);
  endtask

  task automatic refresh_pools();
    foreach (user_pool[i]) user_pool[i] = $urandom;
    foreach (proc_pool[i]) proc_pool[i] = PROC_W'($urandom);
    foreach (stamp_pool[i]) stamp_pool[i] = {$urandom, $urandom};
    stamp_pool[0] = '0;  // zero is an ordinary stamp for lookup and grant
  endtask

  // Mostly pooled keys so the table fills, hits and overflows; some fully
  // random words to toggle every bit.
  task automatic offer_random();
    int unsigned        pick;
    logic [1:0]         f;
    logic [USER_W-1:0]  u;
    logic [PROC_W-1:0]  p;
    logic [STAMP_W-1:0] s;
    pick = $urandom_range(99);
    if (pick < 35)      f = FN_LOOKUP;
    else if (pick < 75) f = FN_GRANT;
    else if (pick < 95) f = FN_REVOKE;
    else                f = FN_NONE;
    if ($urandom_range(99) < 15) begin
      u = $urandom;
      p = PROC_W'($urandom);
      s = {$urandom, $urandom};
    end else begin
      u = user_pool[$urandom_range(3)];
      p = proc_pool[$urandom_range(2)];
      s = stamp_pool[$urandom_range(3)];
      if (f == FN_REVOKE && $urandom_range(99) < 40) s = '0;  // wildcard revoke
    end
    offer_word(f, u, p, s);
  endtask

  // Corner words: field extremes, every op, unused code, stamp zero on
  // lookup/grant, wildcard and mismatching revoke, full-table overwrite of
  // slot 0, and one revoke clearing the whole table.
  task automatic run_corner_words();
    offer_word(FN_LOOKUP, '0, '0, '0);       // empty table: zero keys must miss
    offer_word(FN_NONE,   '1, '1, '1);       // unused code: no effect, all-zero reply
    offer_word(FN_GRANT,  '0, '0, '0);       // slot 0
    offer_word(FN_LOOKUP, '0, '0, '0);       // hit, slot 0
    offer_word(FN_LOOKUP, '0, '0, 64'd1);    // stamp differs: miss
    offer_word(FN_GRANT,  '1, '1, '1);       // slot 1
    offer_word(FN_GRANT,  '1, '1, '1);       // reuse slot 1
    offer_word(FN_REVOKE, '1, '1, '0);       // wildcard clears slot 1
    offer_word(FN_REVOKE, '0, '0, 64'd5);    // stamp mismatch: nothing cleared
    offer_word(FN_REVOKE, '0, '0, '0);       // clears slot 0
    for (int i = 1; i <= SLOTS; i++)
      offer_word(FN_GRANT, 32'hA5A5_0F0F, 31'h2AAA_5555, 64'(i));
    offer_word(FN_GRANT,  32'hA5A5_0F0F, 31'h2AAA_5555, 64'd99);  // full: slot 0 overwritten
    offer_word(FN_LOOKUP, 32'hA5A5_0F0F, 31'h2AAA_5555, 64'd1);   // lost with slot 0
    offer_word(FN_REVOKE, 32'hA5A5_0F0F, 31'h2AAA_5555, '0);      // clears all sixteen
  endtask

  initial begin : stimulus
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    run_corner_words();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 61; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 6;  stall_pct = 6;  end
      endcase
      refresh_pools();
      for (int n = 0; n < PHASE_WORDS; n++) begin
        // receiver goes quiet while words keep coming: block fills and stalls
        if (phase == 0 && n == 120) hold_start = 1'b1;
        offer_random();
      end
      // sender pauses until every reply due has come back
      in_valid <= 1'b0;
      while (mirror.pending() != 0) @(posedge clk);
    end
    repeat (4 * (SLOTS + 3)) @(posedge clk);
    if (mirror.fails == 0 && mirror.pending() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
